>>> hdl/amlg_pkg.sv
// amlg_pkg: shared types and constants of the angular margin logit block
// no dependencies; imported by every module of the block
package amlg_pkg;

    // margin type register codes
    typedef enum logic [1:0] {
        MARGIN_PLAIN  = 2'd0,
        MARGIN_DOUBLE = 2'd1,
        MARGIN_TRIPLE = 2'd2,
        MARGIN_QUAD   = 2'd3
    } t_margin;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MARGIN_TYPE = 2'd0,
        CFG_LAMBDA      = 2'd1,
        CFG_INV_GAIN    = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    localparam int CFG_DATA_W = 32;
    localparam int LAMBDA_W   = 32;
    localparam int INV_W      = 17;
    localparam int INV_FRAC   = 16;
    localparam logic [INV_W-1:0] INV_RESET = 17'h10000;

endpackage

>>> hdl/amlg_div.sv
// amlg_div: one-bit-per-stage restoring divider forming the clamped cosine
// depends on amlg_pkg
module amlg_div import amlg_pkg::*; #(
    parameter int F = 16,
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [W-1:0] i_dot,
    input  logic [W-1:0]        i_norm,
    input  logic                i_tgt,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [F+1:0] o_cos,
    output logic signed [W-1:0] o_dot,
    output logic [W-1:0]        o_norm,
    output logic                o_tgt
);

    localparam int RW = W + 1;

    logic [F:0]          r_v;
    logic [F:0]          w_adv;
    logic [RW-1:0]       r_rem  [0:F];
    logic [F-1:0]        r_q    [0:F];
    logic signed [W-1:0] r_dot  [0:F];
    logic [W-1:0]        r_norm [0:F];
    logic [F:0]          r_tgt;
    logic [F:0]          r_big;

    logic [W-1:0]        w_mag;
    logic                w_big;
    logic [F:0]          w_cmag;
    logic signed [F+1:0] w_cpos;

    assign w_mag = i_dot[W-1] ? (~i_dot + 1'b1) : i_dot;
    assign w_big = (w_mag >= i_norm);

    // stage advance chain, bubbles collapse
    assign w_adv[F] = !r_v[F] || i_ready;
    for (genvar k = 0; k < F; k++) begin : g_adv
        assign w_adv[k] = !r_v[k] || w_adv[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_adv[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_valid) begin
            r_rem[0]  <= {1'b0, w_mag};
            r_q[0]    <= '0;
            r_dot[0]  <= i_dot;
            r_norm[0] <= i_norm;
            r_tgt[0]  <= i_tgt;
            r_big[0]  <= w_big;
        end
    end

    for (genvar k = 1; k <= F; k++) begin : g_stage
        logic [RW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = {r_rem[k-1][W-1:0], 1'b0};
        assign w_ge = (w_sh >= {1'b0, r_norm[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_adv[k]) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[k] && r_v[k-1]) begin
                r_rem[k]  <= w_ge ? (w_sh - {1'b0, r_norm[k-1]}) : w_sh;
                r_q[k]    <= {r_q[k-1][F-2:0], w_ge};
                r_dot[k]  <= r_dot[k-1];
                r_norm[k] <= r_norm[k-1];
                r_tgt[k]  <= r_tgt[k-1];
                r_big[k]  <= r_big[k-1];
            end
        end
    end

    // clamp to one when |dot| >= norm, zero norm gives zero
    assign w_cmag = r_big[F] ? {1'b1, {F{1'b0}}} : {1'b0, r_q[F]};
    assign w_cpos = $signed({1'b0, w_cmag});

    always_comb begin
        if (r_norm[F] == '0) begin
            o_cos = '0;
        end else if (r_dot[F][W-1]) begin
            o_cos = -w_cpos;
        end else begin
            o_cos = w_cpos;
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[F];
    assign o_dot   = r_dot[F];
    assign o_norm  = r_norm[F];
    assign o_tgt   = r_tgt[F];

endmodule

>>> hdl/amlg_psi.sv
// amlg_psi: powers of the cosine and the piecewise margin function psi
// depends on amlg_pkg
module amlg_psi import amlg_pkg::*; #(
    parameter int F = 16,
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_margin              i_margin,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [F+1:0]  i_cos,
    input  logic signed [W-1:0]  i_dot,
    input  logic [W-1:0]         i_norm,
    input  logic                 i_tgt,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [F+5:0]  o_psi,
    output logic signed [W-1:0]  o_dot,
    output logic [W-1:0]         o_norm,
    output logic                 o_tgt
);

    localparam int CW = F + 2;
    localparam int PW = F + 6;
    localparam logic signed [PW-1:0] ONE = {{(PW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

    function automatic logic signed [3:0] f_sign(input logic signed [PW-1:0] x);
        if (x > 0) begin
            return 4'sd1;
        end else if (x < 0) begin
            return -4'sd1;
        end else begin
            return 4'sd0;
        end
    endfunction

    function automatic logic signed [PW-1:0] f_apply(input logic signed [3:0] s,
                                                     input logic signed [PW-1:0] x);
        if (s == 4'sd1) begin
            return x;
        end else if (s == -4'sd1) begin
            return -x;
        end else begin
            return '0;
        end
    endfunction

    logic [2:0] r_v;
    logic [2:0] w_adv;

    // stage a: cos and c2
    logic signed [CW-1:0]   r_cos_a;
    logic [F:0]             r_c2_a;
    logic signed [W-1:0]    r_dot_a, r_dot_b;
    logic [W-1:0]           r_norm_a, r_norm_b;
    logic                   r_tgt_a, r_tgt_b;
    logic signed [2*CW-1:0] w_sq;

    // stage b: c3 and c4
    logic signed [CW-1:0]   r_cos_b;
    logic [F:0]             r_c2_b;
    logic signed [CW-1:0]   r_c3_b;
    logic [F:0]             r_c4_b;
    logic signed [2*CW-1:0] w_p3;
    logic signed [2*CW-1:0] w_p3s;
    logic [2*F+1:0]         w_p4;

    // stage c: psi
    logic signed [PW-1:0] r_psi;
    logic signed [W-1:0]  r_dot_c;
    logic [W-1:0]         r_norm_c;
    logic                 r_tgt_c;

    logic signed [PW-1:0] e_cos, e_c2, e_c3, e_c4, e_ac;
    logic signed [3:0]    s0, s1, s2, s3, s4;
    logic signed [PW-1:0] psi_d, psi_t, psi_q, n_psi;

    assign w_adv[2] = !r_v[2] || i_ready;
    assign w_adv[1] = !r_v[1] || w_adv[2];
    assign w_adv[0] = !r_v[0] || w_adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_adv[1]) begin
                r_v[1] <= r_v[0];
            end
            if (w_adv[2]) begin
                r_v[2] <= r_v[1];
            end
        end
    end

    assign w_sq  = i_cos * i_cos;
    assign w_p3  = $signed({1'b0, r_c2_a}) * r_cos_a;
    assign w_p3s = w_p3 >>> F;
    assign w_p4  = r_c2_a * r_c2_a;

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_valid) begin
            r_cos_a  <= i_cos;
            r_c2_a   <= w_sq[2*F:F];
            r_dot_a  <= i_dot;
            r_norm_a <= i_norm;
            r_tgt_a  <= i_tgt;
        end
        if (w_adv[1] && r_v[0]) begin
            r_cos_b  <= r_cos_a;
            r_c2_b   <= r_c2_a;
            r_c3_b   <= w_p3s[CW-1:0];
            r_c4_b   <= w_p4[2*F:F];
            r_dot_b  <= r_dot_a;
            r_norm_b <= r_norm_a;
            r_tgt_b  <= r_tgt_a;
        end
        if (w_adv[2] && r_v[1]) begin
            r_psi    <= n_psi;
            r_dot_c  <= r_dot_b;
            r_norm_c <= r_norm_b;
            r_tgt_c  <= r_tgt_b;
        end
    end

    always_comb begin
        e_cos = PW'(r_cos_b);
        e_c2  = $signed({{(PW-F-1){1'b0}}, r_c2_b});
        e_c3  = PW'(r_c3_b);
        e_c4  = $signed({{(PW-F-1){1'b0}}, r_c4_b});
        e_ac  = (e_cos < 0) ? -e_cos : e_cos;

        s0 = f_sign(e_cos);
        // triple margin sectors
        s1 = f_sign(e_ac - (ONE >>> 1));
        s2 = s0 * (4'sd1 + s1) - 4'sd2;
        // quadruple margin sectors
        s3 = s0 * f_sign((e_c2 <<< 1) - ONE);
        s4 = (s0 <<< 1) + s3 - 4'sd3;

        psi_d = (f_apply(s0, e_c2) <<< 1) - ONE;
        psi_t = f_apply(s1, (e_c3 <<< 2) - ((e_cos <<< 1) + e_cos)) + (PW'(s2) <<< F);
        psi_q = f_apply(s3, (e_c4 <<< 3) - (e_c2 <<< 3) + ONE) + (PW'(s4) <<< F);

        unique case (i_margin)
            MARGIN_DOUBLE: n_psi = psi_d;
            MARGIN_TRIPLE: n_psi = psi_t;
            MARGIN_QUAD:   n_psi = psi_q;
            default:       n_psi = e_cos;
        endcase
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[2];
    assign o_psi   = r_psi;
    assign o_dot   = r_dot_c;
    assign o_norm  = r_norm_c;
    assign o_tgt   = r_tgt_c;

endmodule

>>> hdl/amlg_blend.sv
// amlg_blend: blend of margin and plain logits, gain, saturation, output register
// depends on amlg_pkg
module amlg_blend import amlg_pkg::*; #(
    parameter int F = 16,
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_margin             i_margin,
    input  logic [LAMBDA_W-1:0] i_lambda,
    input  logic [INV_W-1:0]    i_inv,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [F+5:0] i_psi,
    input  logic signed [W-1:0] i_dot,
    input  logic [W-1:0]        i_norm,
    input  logic                i_tgt,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [W-1:0] o_logit,
    output logic                o_zero,
    output logic                o_sat
);

    localparam int PW   = F + 6;
    localparam int PN   = W + 1 + PW;
    localparam int LD   = LAMBDA_W + 1 + W;
    localparam int SW   = LAMBDA_W + W + 2;
    localparam int HALF = SW / 2;
    localparam int HW   = SW - HALF;
    localparam int PLW  = HALF + INV_W;
    localparam int PHW  = HW + INV_W + 1;
    localparam int PD   = SW + INV_W + 1;

    logic [3:0] r_v;
    logic [3:0] w_adv;

    logic signed [PN-1:0] w_pn;
    logic signed [LD-1:0] w_ld;
    logic signed [SW-1:0] r_pn, r_ld;
    logic signed [SW-1:0] r_sum;
    logic [PLW-1:0]       r_plo;
    logic signed [PHW-1:0] r_phi;
    logic signed [PD-1:0] w_p, w_sh;
    logic                 w_fits;

    logic signed [W-1:0]  r_dot_a, r_dot_b, r_dot_c;
    logic [2:0]           r_zero, r_act;
    logic signed [W-1:0]  r_logit;
    logic                 r_zero_o, r_sat;

    assign w_adv[3] = !r_v[3] || i_ready;
    assign w_adv[2] = !r_v[2] || w_adv[3];
    assign w_adv[1] = !r_v[1] || w_adv[2];
    assign w_adv[0] = !r_v[0] || w_adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < 4; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign w_pn = $signed({1'b0, i_norm}) * i_psi;
    assign w_ld = $signed({1'b0, i_lambda}) * i_dot;

    // recombine the two partial products of sum * gain
    assign w_p  = (PD'(r_phi) <<< HALF) + $signed(PD'(r_plo));
    assign w_sh = w_p >>> (F + INV_FRAC);
    assign w_fits = (&w_sh[PD-1:W-1]) || !(|w_sh[PD-1:W-1]);

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_valid) begin
            r_pn      <= SW'(w_pn);
            r_ld      <= SW'(w_ld);
            r_dot_a   <= i_dot;
            r_zero[0] <= (i_norm == '0);
            r_act[0]  <= i_tgt && (i_margin != MARGIN_PLAIN);
        end
        if (w_adv[1] && r_v[0]) begin
            r_sum     <= r_pn + r_ld;
            r_dot_b   <= r_dot_a;
            r_zero[1] <= r_zero[0];
            r_act[1]  <= r_act[0];
        end
        if (w_adv[2] && r_v[1]) begin
            r_plo     <= r_sum[HALF-1:0] * i_inv;
            r_phi     <= $signed(r_sum[SW-1:HALF]) * $signed({1'b0, i_inv});
            r_dot_c   <= r_dot_b;
            r_zero[2] <= r_zero[1];
            r_act[2]  <= r_act[1];
        end
        if (w_adv[3] && r_v[2]) begin
            r_zero_o <= r_zero[2];
            if (!r_act[2]) begin
                r_logit <= r_dot_c;
                r_sat   <= 1'b0;
            end else if (w_fits) begin
                r_logit <= w_sh[W-1:0];
                r_sat   <= 1'b0;
            end else begin
                r_logit <= w_sh[PD-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                r_sat   <= 1'b1;
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[3];
    assign o_logit = r_logit;
    assign o_zero  = r_zero_o;
    assign o_sat   = r_sat;

endmodule

>>> hdl/angular_margin_logit.sv
// angular_margin_logit: top level, configuration registers and pipeline wiring
// depends on amlg_pkg, amlg_div, amlg_psi, amlg_blend
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  input    | i_in_valid / o_in_stall   | i_dot_product, i_sample_norm, i_is_target_class
//  output   | o_out_valid / i_out_stall | o_logit, o_zero_norm, o_saturated
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; the pipeline is the
// one-bit-per-stage divider followed by three psi stages and four blend stages
// reset (synchronous, active low) clears all valid bits and loads register defaults
// a stalled output holds its register; stages behind it keep filling bubbles,
// and o_in_stall rises only when every stage holds an item
module angular_margin_logit import amlg_pkg::*; #(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_dot_product,
    input  logic [VALUE_WIDTH-1:0]        i_sample_norm,
    input  logic                          i_is_target_class,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [VALUE_WIDTH-1:0] o_logit,
    output logic                          o_zero_norm,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int F = FRAC_BITS;
    localparam int W = VALUE_WIDTH;

    // configuration registers
    t_margin             r_margin;
    logic [LAMBDA_W-1:0] r_lambda;
    logic [INV_W-1:0]    r_inv;

    // divider -> psi
    logic                d_valid, d_ready;
    logic signed [F+1:0] d_cos;
    logic signed [W-1:0] d_dot;
    logic [W-1:0]        d_norm;
    logic                d_tgt;

    // psi -> blend
    logic                p_valid, p_ready;
    logic signed [F+5:0] p_psi;
    logic signed [W-1:0] p_dot;
    logic [W-1:0]        p_norm;
    logic                p_tgt;

    logic                in_ready;

    // register writes always taken; an unused index is dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_PLAIN;
            r_lambda <= '0;
            r_inv    <= INV_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MARGIN_TYPE: r_margin <= t_margin'(i_cfg_data[1:0]);
                CFG_LAMBDA:      r_lambda <= i_cfg_data[LAMBDA_W-1:0];
                CFG_INV_GAIN:    r_inv    <= i_cfg_data[INV_W-1:0];
                default:         ;
            endcase
        end
    end

    // cosine by restoring division, one quotient bit per stage
    amlg_div #(.F(F), .W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (in_ready),
        .i_dot   (i_dot_product),
        .i_norm  (i_sample_norm),
        .i_tgt   (i_is_target_class),
        .o_valid (d_valid),
        .i_ready (d_ready),
        .o_cos   (d_cos),
        .o_dot   (d_dot),
        .o_norm  (d_norm),
        .o_tgt   (d_tgt)
    );

    // cos^2, cos^3, cos^4 and the sector-wise psi
    amlg_psi #(.F(F), .W(W)) u_psi (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_margin (r_margin),
        .i_valid  (d_valid),
        .o_ready  (d_ready),
        .i_cos    (d_cos),
        .i_dot    (d_dot),
        .i_norm   (d_norm),
        .i_tgt    (d_tgt),
        .o_valid  (p_valid),
        .i_ready  (p_ready),
        .o_psi    (p_psi),
        .o_dot    (p_dot),
        .o_norm   (p_norm),
        .o_tgt    (p_tgt)
    );

    // norm*psi + lambda*dot, gain, clip; last stage is the output register
    amlg_blend #(.F(F), .W(W)) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_margin (r_margin),
        .i_lambda (r_lambda),
        .i_inv    (r_inv),
        .i_valid  (p_valid),
        .o_ready  (p_ready),
        .i_psi    (p_psi),
        .i_dot    (p_dot),
        .i_norm   (p_norm),
        .i_tgt    (p_tgt),
        .o_valid  (o_out_valid),
        .i_ready  (!i_out_stall),
        .o_logit  (o_logit),
        .o_zero   (o_zero_norm),
        .o_sat    (o_saturated)
    );

    assign o_in_stall = !in_ready;

endmodule

>>> tb/sv/tb_angular_margin_logit.sv
`timescale 1ns / 1ps
// tb_angular_margin_logit: self-checking testbench of the angular margin logit block
// drives random and directed items under back pressure, checks each result against
// an in-bench predictor; depends on amlg_pkg and angular_margin_logit
module tb_angular_margin_logit;
    import amlg_pkg::*;

    localparam int F  = 16;
    localparam int VW = 32;
    localparam longint ONE = 64'sd1 << F;
    localparam int DRAIN_CYCLES = 40;   // comfortably above the pipeline latency

    typedef struct packed {
        logic signed [VW-1:0] logit;
        logic                 zero_norm;
        logic                 saturated;
    } t_logit_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [VW-1:0] i_dot_product;
    logic [VW-1:0]        i_sample_norm;
    logic                 i_is_target_class;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [VW-1:0] o_logit;
    logic                 o_zero_norm;
    logic                 o_saturated;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    angular_margin_logit i_dut (.*);

    // shadow copy of the configuration registers
    logic [1:0]        cur_margin;
    logic [LAMBDA_W-1:0] cur_lambda;
    logic [INV_W-1:0]  cur_inv;

    t_logit_result pending_logits[$];
    int  n_fail;
    int  n_items;
    int  n_checked;
    int  n_sat;
    int  n_zero;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_left;

    // clock, 4 ns period
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint sgn64(input longint x);
        return (x > 0) ? 64'sd1 : ((x < 0) ? -64'sd1 : 64'sd0);
    endfunction

    // expected result of one item under the current register values
    function automatic t_logit_result predict_logit(input logic signed [VW-1:0] dot,
                                                    input logic [VW-1:0] norm,
                                                    input logic tgt);
        t_logit_result r;
        longint dotl, mag, c, c2, c3, c4, psi, s0, s1, s2, s3, s4;
        logic signed [127:0] sum, prod, q;
        dotl = dot;
        r.logit = dot;
        r.zero_norm = (norm == '0);
        r.saturated = 1'b0;
        if (tgt && cur_margin != MARGIN_PLAIN) begin
            mag = (dotl < 0) ? -dotl : dotl;
            if (norm == '0)
                c = 0;
            else if (mag >= longint'(norm))
                c = (dotl < 0) ? -ONE : ONE;
            else begin
                c = (mag << F) / longint'(norm);
                if (dotl < 0) c = -c;
            end
            s0 = sgn64(c);
            c2 = (c * c) >>> F;
            c3 = (c2 * c) >>> F;
            c4 = (c2 * c2) >>> F;
            if (cur_margin == MARGIN_DOUBLE)
                psi = 2 * s0 * c2 - ONE;
            else if (cur_margin == MARGIN_TRIPLE) begin
                s1 = sgn64(((c < 0) ? -c : c) - ONE / 2);
                s2 = s0 * (1 + s1) - 2;
                psi = s1 * (4 * c3 - 3 * c) + s2 * ONE;
            end else begin
                s3 = s0 * sgn64(2 * c2 - ONE);
                s4 = 2 * s0 + s3 - 3;
                psi = s3 * (8 * c4 - 8 * c2 + ONE) + s4 * ONE;
            end
            sum = $signed({96'd0, norm}) * 128'(psi)
                + $signed({96'd0, cur_lambda}) * 128'(dotl);
            prod = sum * $signed({111'd0, cur_inv});
            q = prod >>> (F + INV_FRAC);
            if (q > 128'sh7fffffff || q < -128'sh80000000) begin
                r.saturated = 1'b1;
                r.logit = q[127] ? 32'sh80000000 : 32'sh7fffffff;
            end else
                r.logit = q[VW-1:0];
        end
        return r;
    endfunction

    // output checker, one result per accepted item
    always @(posedge i_clk) begin
        t_logit_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_logits.size() == 0) begin
                $error("unexpected result logit %0d", o_logit);
                n_fail++;
            end else begin
                exp_r = pending_logits.pop_front();
                n_checked++;
                if (o_logit !== exp_r.logit) begin
                    $error("logit expected %0d actual %0d", exp_r.logit, o_logit);
                    n_fail++;
                end
                if (o_zero_norm !== exp_r.zero_norm) begin
                    $error("zero_norm expected %0b actual %0b", exp_r.zero_norm, o_zero_norm);
                    n_fail++;
                end
                if (o_saturated !== exp_r.saturated) begin
                    $error("saturated expected %0b actual %0b", exp_r.saturated, o_saturated);
                    n_fail++;
                end
            end
        end
    end

    // receiver side: random stalls, or a long counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else
            i_out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    // one item, held until the block takes it; valid stays high afterwards unless a sender gap drops it
    task automatic send_item(input logic signed [VW-1:0] dot, input logic [VW-1:0] norm,
                             input logic tgt);
        t_logit_result r;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_dot_product = dot;
        i_sample_norm = norm;
        i_is_target_class = tgt;
        do @(posedge i_clk); while (o_in_stall);
        r = predict_logit(dot, norm, tgt);
        pending_logits.push_back(r);
        n_items++;
        if (r.saturated) n_sat++;
        if (r.zero_norm) n_zero++;
        // random gap on the sender side
        if ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // wait until every expected result has come, then let the pipeline settle
    task automatic drain();
        stop_sending();
        while (pending_logits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MARGIN_TYPE: cur_margin = data[1:0];
            CFG_LAMBDA:      cur_lambda = data;
            CFG_INV_GAIN:    cur_inv = data[INV_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // registers change only with the pipeline empty
    task automatic set_config(input t_margin m, input logic [31:0] lam, input logic [16:0] inv);
        drain();
        write_reg(CFG_MARGIN_TYPE, m);
        write_reg(CFG_LAMBDA, lam);
        write_reg(CFG_INV_GAIN, {15'd0, inv});
    endtask

    // random item, mostly with |dot| below the norm so the cosine is interesting
    task automatic send_random_item();
        logic [VW-1:0] norm;
        logic signed [VW-1:0] dot;
        int kind;
        kind = $urandom_range(99);
        case ($urandom_range(3))
            0: norm = $urandom_range(255);
            1: norm = $urandom_range(32'h000fffff);
            2: norm = $urandom_range(32'h3fffffff);
            default: norm = $urandom;
        endcase
        if (kind < 5)
            norm = '0;
        if (kind < 15)
            dot = $urandom;
        else if (kind < 25)
            dot = (($urandom_range(1)) ? -1 : 1) * $signed({1'b0, norm[VW-1:1]});
        else begin
            dot = $signed(32'($urandom_range(norm[VW-1:1] + 1)));
            if ($urandom_range(1)) dot = -dot;
        end
        send_item(dot, norm, $urandom_range(99) < 80);
    endtask

    task automatic random_config();
        logic [31:0] lam;
        logic [16:0] inv;
        case ($urandom_range(3))
            0: lam = 0;
            1: lam = 32'hffffffff;
            default: lam = $urandom_range(32'h00040000);
        endcase
        case ($urandom_range(3))
            0: inv = 17'h10000;
            1: inv = 17'h1ffff;
            2: inv = 0;
            default: inv = $urandom_range(17'h10000);
        endcase
        set_config(t_margin'($urandom_range(3)), lam, inv);
    endtask

    // extremes, every margin type, zero norm, clamp, half-angle boundary, clipping
    task automatic test_directed();
        t_margin m;
        set_config(MARGIN_PLAIN, 32'h00010000, 17'h08000);
        send_item(32'sh7fffffff, 32'h00010000, 1'b1);
        send_item(32'sh80000000, 32'h0, 1'b1);
        send_item(32'sh00001234, 32'hffffffff, 1'b0);
        for (int k = 1; k <= 3; k++) begin
            m = t_margin'(k);
            set_config(m, 32'h00010000, 17'h08000);
            send_item(32'sh00020000, 32'h00010000, 1'b1);   // clamp to +1
            send_item(-32'sh00020000, 32'h00010000, 1'b1);  // clamp to -1
            send_item(32'sh00008000, 32'h00010000, 1'b1);   // exactly one half
            send_item(-32'sh00008000, 32'h00010000, 1'b1);
            send_item(32'sh0, 32'h00010000, 1'b1);          // zero cosine
            send_item(32'sh00005000, 32'h0, 1'b1);          // zero norm
            send_item(32'sh00005000, 32'h00010000, 1'b0);   // other class
        end
        // clipping both ways with the largest gain
        set_config(MARGIN_QUAD, 32'hffffffff, 17'h1ffff);
        send_item(32'sh7fffffff, 32'hffffffff, 1'b1);
        send_item(32'sh80000000, 32'hffffffff, 1'b1);
        send_item(32'sh80000000, 32'h0, 1'b0);
        drain();
        write_reg(CFG_UNUSED, 32'hdeadbeef);   // unused index must be ignored
        set_config(MARGIN_DOUBLE, 0, 17'h0);
        send_item(32'sh00003000, 32'h00010000, 1'b1);
        drain();
    endtask

    task automatic test_random(input int s_pct, input int r_pct, input int n);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int p = 0; p < 4; p++) begin
            random_config();
            for (int i = 0; i < n / 4; i++) send_random_item();
            drain();
        end
    endtask

    // long receiver hold-off while the sender keeps offering items
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_config(MARGIN_TRIPLE, 32'h00008000, 17'h0aaab);
        @(negedge i_clk);
        hold_left = 150;
        for (int i = 0; i < 80; i++) send_random_item();
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_dot_product = '0;
        i_sample_norm = '0;
        i_is_target_class = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MARGIN_TYPE;
        i_cfg_data = '0;
        cur_margin = MARGIN_PLAIN;
        cur_lambda = '0;
        cur_inv = INV_RESET;
        n_fail = 0;
        n_items = 0;
        n_checked = 0;
        n_sat = 0;
        n_zero = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values first, with one item before any write
        send_item(32'sh00012345, 32'h00020000, 1'b1);
        drain();
        test_directed();
        test_random(17, 79, 520);
        test_random(79, 17, 520);
        test_random(0, 0, 520);
        test_backpressure();

        $display("covered %0d items (%0d checked), %0d clipped, %0d with zero norm",
                 n_items, n_checked, n_sat, n_zero);
        if (n_fail == 0)
            $display("PASS angular_margin_logit");
        else
            $display("FAIL angular_margin_logit");
        $finish;
    end

    // watchdog
    initial begin
        #4ms;
        $display("FAIL angular_margin_logit");
        $finish;
    end

endmodule

>>> angular_margin_logit.f
hdl/amlg_pkg.sv
hdl/amlg_div.sv
hdl/amlg_psi.sv
hdl/amlg_blend.sv
hdl/angular_margin_logit.sv
tb/sv/tb_angular_margin_logit.sv
